// ===== src/indexed_list_store_unit_macros.svh =====
// Assertion macros for the indexed list store.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef INDEXED_LIST_STORE_UNIT_MACROS_SVH
`define INDEXED_LIST_STORE_UNIT_MACROS_SVH

// check active outside reset
`define ILST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check active on every edge, reset included
`define ILST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ilst_pkg.sv =====
// Shared constants and types for the indexed list store.
// No dependencies.
`default_nettype none
package ilst_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int OP_W         = 3;
  localparam int STAT_W       = 2;
  localparam int LEN_W        = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] NO_VALUE = '1;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/ilst_cell.sv =====
// One storage cell of the list chain: holds one entry and a read-out stage.
// Depends on ilst_pkg.
`default_nettype none
module ilst_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ilst_pkg::cell_ctrl_t      ctrl,
  input  wire logic [IW-1:0]             slot,
  input  wire logic [ilst_pkg::DATA_W-1:0] ins_value,
  input  wire logic [ilst_pkg::DATA_W-1:0] left_elem,
  input  wire logic [ilst_pkg::DATA_W-1:0] right_elem,
  input  wire logic [ilst_pkg::DATA_W-1:0] right_rd_data,
  input  wire logic                      right_rd_vld,
  output logic      [ilst_pkg::DATA_W-1:0] elem,
  output logic      [ilst_pkg::DATA_W-1:0] rd_data,
  output logic                           rd_vld
);
  import ilst_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic hit;
  logic above;

  assign hit   = (slot == MY_IDX);
  assign above = (MY_IDX > slot);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        elem <= ins_value;
      end else if (above) begin
        elem <= left_elem;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        elem <= right_elem;
      end
    end
  end

  // read-out chain: selected entry walks toward cell 0
  always_ff @(posedge clk) begin
    rd_data <= (ctrl.rd && hit) ? elem : right_rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (ctrl.rd && hit) || right_rd_vld;
    end
  end

endmodule
`default_nettype wire

// ===== src/indexed_list_store_unit.sv =====
// Indexed list store: ordered list of 32-bit words in a chain of cells.
// Insert, append, delete and rejected ops give their result word in the cycle after accept.
// A valid read walks the entry down the read chain to cell 0, then into the output register.
// One word in flight; 1 word per cycle unless output stalls; reads block input until done.
// Reset clears the length, state, read chain flags and output valid; entries stay undefined.
// Depends on ilst_pkg, ilst_cell and indexed_list_store_unit_macros.svh.
`default_nettype none
`include "indexed_list_store_unit_macros.svh"
module indexed_list_store_unit #(
  parameter int CAPACITY = ilst_pkg::DEF_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // position[15:0], value[47:16]
  input  wire logic [2:0]  s_tuser,  // opcode[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,  // read_value[31:0], status[33:32], length[40:34]
  output logic             m_tuser   // read_valid[0]
);
  import ilst_pkg::*;

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  fsm_t state, state_next;

  logic [CW-1:0]     count, count_next;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic              accept;
  logic              pos_neg;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              in_range, beyond, full;
  logic              do_ins, do_del, launch;
  logic [STAT_W-1:0] res_status;
  logic [IW-1:0]     slot;
  cell_ctrl_t        ctrl;
  logic              read_done;
  logic              out_load;

  logic [DATA_W-1:0] out_value;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0]  out_length;
  logic              out_rd_valid;

  logic [DATA_W-1:0] elem [CAPACITY];
  logic [DATA_W-1:0] rdd  [CAPACITY];
  logic [CAPACITY-1:0] rdv;

  assign op  = s_tuser;
  assign pos = s_tdata[POS_W-1:0];
  assign val = s_tdata[POS_W +: DATA_W];

  assign accept   = s_tvalid && s_tready;
  assign pos_neg  = pos[POS_W-1];
  assign pos_ext  = CMP_W'(pos[POS_W-2:0]);
  assign cnt_ext  = CMP_W'(count);
  assign in_range = !pos_neg && (pos_ext < cnt_ext);
  assign beyond   = !pos_neg && (pos_ext > cnt_ext);
  assign full     = (count == CAP_CNT);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    launch     = 1'b0;
    res_status = ST_DONE;
    slot       = IW'(pos[POS_W-2:0]);
    unique case (op)
      OP_READ: begin
        if (in_range) begin
          launch = 1'b1;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_INS_HEAD: begin
        slot = '0;
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_APPEND: begin
        slot = IW'(count);
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_INS_BEFORE: begin
        if (pos_neg) begin
          slot = '0;
        end
        if (beyond) begin
          res_status = ST_RANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          do_del = 1'b1;
        end else begin
          res_status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.ins = accept && do_ins;
  assign ctrl.del = accept && do_del;
  assign ctrl.rd  = accept && launch;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_e, right_e, right_d;
      logic              right_v;
      if (i == 0) begin : g_head
        assign left_e = elem[0];
      end else begin : g_mid
        assign left_e = elem[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign right_e = elem[i];
        assign right_d = NO_VALUE;
        assign right_v = 1'b0;
      end else begin : g_body
        assign right_e = elem[i+1];
        assign right_d = rdd[i+1];
        assign right_v = rdv[i+1];
      end
      ilst_cell #(
        .IW  (IW),
        .IDX (i)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .slot          (slot),
        .ins_value     (val),
        .left_elem     (left_e),
        .right_elem    (right_e),
        .right_rd_data (right_d),
        .right_rd_vld  (right_v),
        .elem          (elem[i]),
        .rd_data       (rdd[i]),
        .rd_vld        (rdv[i])
      );
    end
  endgenerate

  assign read_done = (state == FSM_READ) && rdv[0];

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (ctrl.rd) begin
          state_next = FSM_READ;
        end
      end
      FSM_READ: begin
        if (rdv[0]) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      FSM_IDLE: s_tready = !m_tvalid || m_tready;
      FSM_READ: s_tready = 1'b0;
      default:  s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_load = (accept && !launch) || read_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_done) begin
      out_value    <= rdd[0];
      out_status   <= ST_DONE;
      out_length   <= LEN_W'(count);
      out_rd_valid <= 1'b1;
    end else if (accept && !launch) begin
      out_value    <= NO_VALUE;
      out_status   <= res_status;
      out_length   <= LEN_W'(count_next);
      out_rd_valid <= 1'b0;
    end
  end

  assign m_tdata = {7'b0, out_length, out_status, out_value};
  assign m_tuser = out_rd_valid;

  `ILST_ASSERT(a_count_cap, (count <= CAP_CNT), "list length above capacity")
  `ILST_ASSERT(a_read_chain, $onehot0(rdv), "more than one word on the read chain")
  `ILST_ASSERT(a_read_hold, (state == FSM_READ) |=> (count == $past(count)), "length moved during read")
  `ILST_ASSERT(a_read_stall, (state == FSM_READ) |-> !s_tready, "input taken during read")

endmodule
`default_nettype wire
